>>> design/olist_pkg.sv
// shared types, constants and codes for the ordered list engine
package olist_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 5;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_POS = 2'd1,
    CMD_DEL_VAL = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PTR_COUNT = 2'd0,
    PTR_POS   = 2'd1,
    PTR_ZERO  = 2'd2,
    PTR_MATCH = 2'd3
  } ptr_sel_e;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SHIFT_UP = 8'b0000_0010,
    S_INS_WR   = 8'b0000_0100,
    S_SHIFT_DN = 8'b0000_1000,
    S_SEARCH   = 8'b0001_0000,
    S_RD_ISSUE = 8'b0010_0000,
    S_RD_WAIT  = 8'b0100_0000,
    S_EMIT     = 8'b1000_0000
  } state_e;

  typedef struct packed {
    logic     capture;
    logic     load;
    ptr_sel_e ptr_sel;
    logic     step_up;
    logic     step_dn;
    logic     srch_step;
    logic     rd_issue;
    logic     rd_emit;
    logic     ins_write;
    logic     cnt_inc;
    logic     cnt_dec;
    logic     st_load;
    status_e  st_code;
    logic     emit;
  } olist_ctl_t;

  typedef struct packed {
    logic ins_pos_ok;
    logic del_pos_ok;
    logic empty;
    logic full;
    logic up_done;
    logic walk_done;
    logic wr_pend;
    logic rd_vld;
    logic match;
    logic rd_last;
    logic out_free;
  } olist_sts_t;

endpackage

>>> design/olist_ctrl.sv
// command sequencer for the ordered list engine
module olist_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  olist_pkg::cmd_e        cmd_i,
  input  olist_pkg::olist_sts_t  sts_i,
  output logic                   in_ready_o,
  output olist_pkg::olist_ctl_t  ctl_o
);

  olist_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == olist_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      olist_pkg::S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.capture = 1'b1;
          ctl_o.st_load = 1'b1;
          case (cmd_i)
            olist_pkg::CMD_INSERT: begin
              if (!sts_i.ins_pos_ok) begin
                ctl_o.st_code = olist_pkg::ST_BADPOS;
                state_d       = olist_pkg::S_EMIT;
              end else if (sts_i.full) begin
                ctl_o.st_code = olist_pkg::ST_FULL;
                state_d       = olist_pkg::S_EMIT;
              end else begin
                ctl_o.st_code = olist_pkg::ST_OK;
                ctl_o.load    = 1'b1;
                ctl_o.ptr_sel = olist_pkg::PTR_COUNT;
                state_d       = olist_pkg::S_SHIFT_UP;
              end
            end
            olist_pkg::CMD_DEL_POS: begin
              if (sts_i.empty) begin
                ctl_o.st_code = olist_pkg::ST_EMPTY;
                state_d       = olist_pkg::S_EMIT;
              end else if (!sts_i.del_pos_ok) begin
                ctl_o.st_code = olist_pkg::ST_BADPOS;
                state_d       = olist_pkg::S_EMIT;
              end else begin
                ctl_o.st_code = olist_pkg::ST_OK;
                ctl_o.load    = 1'b1;
                ctl_o.ptr_sel = olist_pkg::PTR_POS;
                state_d       = olist_pkg::S_SHIFT_DN;
              end
            end
            olist_pkg::CMD_DEL_VAL: begin
              if (sts_i.empty) begin
                ctl_o.st_code = olist_pkg::ST_EMPTY;
                state_d       = olist_pkg::S_EMIT;
              end else begin
                ctl_o.st_code = olist_pkg::ST_NOTFOUND;
                ctl_o.load    = 1'b1;
                ctl_o.ptr_sel = olist_pkg::PTR_ZERO;
                state_d       = olist_pkg::S_SEARCH;
              end
            end
            default: begin
              if (sts_i.empty) begin
                ctl_o.st_code = olist_pkg::ST_EMPTY;
                state_d       = olist_pkg::S_EMIT;
              end else begin
                ctl_o.st_code = olist_pkg::ST_OK;
                ctl_o.load    = 1'b1;
                ctl_o.ptr_sel = olist_pkg::PTR_ZERO;
                state_d       = olist_pkg::S_RD_ISSUE;
              end
            end
          endcase
        end
      end
      olist_pkg::S_SHIFT_UP: begin
        if (!sts_i.up_done) begin
          ctl_o.step_up = 1'b1;
        end else if (!sts_i.wr_pend) begin
          state_d = olist_pkg::S_INS_WR;
        end
      end
      olist_pkg::S_INS_WR: begin
        ctl_o.ins_write = 1'b1;
        ctl_o.cnt_inc   = 1'b1;
        state_d         = olist_pkg::S_EMIT;
      end
      olist_pkg::S_SHIFT_DN: begin
        if (!sts_i.walk_done) begin
          ctl_o.step_dn = 1'b1;
        end else if (!sts_i.wr_pend) begin
          ctl_o.cnt_dec = 1'b1;
          state_d       = olist_pkg::S_EMIT;
        end
      end
      olist_pkg::S_SEARCH: begin
        if (sts_i.match) begin
          ctl_o.st_load = 1'b1;
          ctl_o.st_code = olist_pkg::ST_OK;
          ctl_o.load    = 1'b1;
          ctl_o.ptr_sel = olist_pkg::PTR_MATCH;
          state_d       = olist_pkg::S_SHIFT_DN;
        end else if (!sts_i.walk_done) begin
          ctl_o.srch_step = 1'b1;
        end else if (!sts_i.rd_vld) begin
          state_d = olist_pkg::S_EMIT;
        end
      end
      olist_pkg::S_RD_ISSUE: begin
        ctl_o.rd_issue = 1'b1;
        state_d        = olist_pkg::S_RD_WAIT;
      end
      olist_pkg::S_RD_WAIT: begin
        if (sts_i.out_free) begin
          ctl_o.rd_emit = 1'b1;
          state_d       = sts_i.rd_last ? olist_pkg::S_IDLE : olist_pkg::S_RD_ISSUE;
        end
      end
      olist_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          ctl_o.emit = 1'b1;
          state_d    = olist_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = olist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olist_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> design/olist_dpath.sv
// element store, walk pointer, count and result register of the ordered list engine
module olist_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olist_pkg::olist_ctl_t               ctl_i,
  input  logic [olist_pkg::POS_W-1:0]         position_i,
  input  logic signed [olist_pkg::DATA_W-1:0] item_value_i,
  input  logic                                out_ready_i,
  output olist_pkg::olist_sts_t               sts_o,
  output logic                                out_valid_o,
  output logic [olist_pkg::STAT_W-1:0]        status_o,
  output logic signed [olist_pkg::DATA_W-1:0] read_value_o,
  output logic [olist_pkg::CNT_W-1:0]         element_count_o,
  output logic                                last_of_run_o
);

  localparam int IW = olist_pkg::IDX_W;
  localparam int CW = olist_pkg::CNT_W;
  localparam int DW = olist_pkg::DATA_W;

  logic [DW-1:0] mem [olist_pkg::CAPACITY];
  logic [DW-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] jm1, jp1;
  logic [CW-1:0] k_q;
  logic [DW-1:0] val_q;
  logic          wr_pend_q;
  logic [IW-1:0] wr_addr_q;
  logic          rd_vld_q;
  logic [IW-1:0] rd_idx_q;
  logic [olist_pkg::STAT_W-1:0] stat_q;

  logic          out_valid_q;
  logic [olist_pkg::STAT_W-1:0] out_status_q;
  logic [DW-1:0] out_value_q;
  logic [CW-1:0] out_count_q;
  logic          out_last_q;
  logic          out_load;
  logic [CW:0]   pos_ext;
  logic [CW:0]   cnt_p1;

  assign jm1     = j_q - CW'(1);
  assign jp1     = j_q + CW'(1);
  assign pos_ext = {1'b0, CW'(position_i)};
  assign cnt_p1  = {1'b0, count_q} + (CW + 1)'(1);

  always_comb begin
    sts_o.ins_pos_ok = (position_i != '0) && (pos_ext <= cnt_p1);
    sts_o.del_pos_ok = (position_i != '0) && (CW'(position_i) <= count_q);
    sts_o.empty      = (count_q == '0);
    sts_o.full       = (count_q == CW'(olist_pkg::CAPACITY));
    sts_o.up_done    = (j_q <= k_q);
    sts_o.walk_done  = (j_q >= count_q);
    sts_o.wr_pend    = wr_pend_q;
    sts_o.rd_vld     = rd_vld_q;
    sts_o.match      = rd_vld_q && (rdata_q == val_q);
    sts_o.rd_last    = (jp1 == count_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign mem_we    = wr_pend_q | ctl_i.ins_write;
  assign mem_waddr = ctl_i.ins_write ? k_q[IW-1:0] : wr_addr_q;
  assign mem_wdata = ctl_i.ins_write ? val_q : rdata_q;
  assign mem_re    = ctl_i.step_up | ctl_i.step_dn | ctl_i.srch_step | ctl_i.rd_issue;
  assign mem_raddr = ctl_i.step_up ? jm1[IW-1:0] : j_q[IW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_comb begin
    j_d = j_q;
    if (ctl_i.load) begin
      case (ctl_i.ptr_sel)
        olist_pkg::PTR_COUNT: j_d = count_q;
        olist_pkg::PTR_POS:   j_d = CW'(position_i);
        olist_pkg::PTR_ZERO:  j_d = '0;
        olist_pkg::PTR_MATCH: j_d = CW'(rd_idx_q) + CW'(1);
        default:              j_d = '0;
      endcase
    end else if (ctl_i.step_up) begin
      j_d = jm1;
    end else if (ctl_i.step_dn || ctl_i.srch_step || ctl_i.rd_emit) begin
      j_d = jp1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl_i.cnt_inc) begin
      count_d = count_q + CW'(1);
    end else if (ctl_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
  end

  assign out_load = ctl_i.emit | ctl_i.rd_emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      j_q         <= '0;
      wr_pend_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      j_q       <= j_d;
      wr_pend_q <= ctl_i.step_up | ctl_i.step_dn;
      rd_vld_q  <= ctl_i.srch_step;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      k_q   <= CW'(position_i) - CW'(1);
      val_q <= $unsigned(item_value_i);
    end
    if (ctl_i.st_load) begin
      stat_q <= ctl_i.st_code;
    end
    if (ctl_i.step_up) begin
      wr_addr_q <= j_q[IW-1:0];
    end else if (ctl_i.step_dn) begin
      wr_addr_q <= jm1[IW-1:0];
    end
    if (ctl_i.srch_step) begin
      rd_idx_q <= j_q[IW-1:0];
    end
    if (ctl_i.emit) begin
      out_status_q <= stat_q;
      out_value_q  <= '0;
      out_count_q  <= count_q;
      out_last_q   <= 1'b1;
    end else if (ctl_i.rd_emit) begin
      out_status_q <= olist_pkg::ST_OK;
      out_value_q  <= rdata_q;
      out_count_q  <= count_q;
      out_last_q   <= sts_o.rd_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign read_value_o    = $signed(out_value_q);
  assign element_count_o = out_count_q;
  assign last_of_run_o   = out_last_q;

endmodule

>>> design/ordered_list_engine_top.sv
// top level of the ordered list engine: bounded ordered list of signed 32-bit values
//
// requests enter on in_valid_i/in_ready_o with cmd_i, position_i and item_value_i;
// results leave on out_valid_o/out_ready_i, one per request except read all of a
// non-empty list, which gives one result per element with last_of_run_o on the last
// in_ready_o is high only while the sequencer is idle: one request at a time
// a rejected request (bad position, full, empty) skips the walk and goes straight to the result
// insert at position p with n held walks n-p+1 elements
// delete at position p walks n-p elements
// delete by value scans one element a cycle until a match, then shifts the rest
// read all reads the elements one at a time through the single memory read port
// a result waits in the output register while the next request is taken; a stalled
// receiver holds the sequencer only when it has a further result to hand over
// reset empties the list at once; the element store itself is not cleared
module ordered_list_engine_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [olist_pkg::CMD_W-1:0]         cmd_i,
  input  logic [olist_pkg::POS_W-1:0]         position_i,
  input  logic signed [olist_pkg::DATA_W-1:0] item_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [olist_pkg::STAT_W-1:0]        status_o,
  output logic signed [olist_pkg::DATA_W-1:0] read_value_o,
  output logic [olist_pkg::CNT_W-1:0]         element_count_o,
  output logic                                last_of_run_o
);

  olist_pkg::olist_ctl_t ctl;
  olist_pkg::olist_sts_t sts;

  olist_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (olist_pkg::cmd_e'(cmd_i)),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .ctl_o      (ctl)
  );

  olist_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctl_i           (ctl),
    .position_i      (position_i),
    .item_value_i    (item_value_i),
    .out_ready_i     (out_ready_i),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .read_value_o    (read_value_o),
    .element_count_o (element_count_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
